/* hw/rtl/dnp3oh_pkg.sv */
// Shared types, codes and helpers for the object header parser.
// Used by the front, queue, back and top-level modules.
package dnp3oh_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_GROUP,
        PH_VAR,
        PH_QUAL,
        PH_RANGE,
        PH_BODY,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        RK_HEADER = 2'd0,
        RK_POINT  = 2'd1,
        RK_ERROR  = 2'd2
    } t_kind;

    localparam logic [3:0] RC_SS8      = 4'h0;
    localparam logic [3:0] RC_SS16     = 4'h1;
    localparam logic [3:0] RC_NONE     = 4'h6;
    localparam logic [3:0] RC_CNT8     = 4'h7;
    localparam logic [3:0] RC_CNT16    = 4'h8;
    localparam logic [3:0] RC_CNT8_ALT = 4'hb;

    localparam logic [7:0] QUAL_INDEX_MASK = 8'h70;
    localparam logic [7:0] FLAG_ON         = 8'h81;
    localparam logic [7:0] FLAG_OFF        = 8'h01;
    localparam logic [1:0] DBL_ON          = 2'b10;
    localparam logic [7:0] GROUP_SINGLE    = 8'd1;
    localparam logic [7:0] GROUP_DOUBLE    = 8'd3;
    localparam logic [7:0] VAR_PACKED      = 8'd1;
    localparam logic [2:0] SLOTS_SINGLE_M1 = 3'd7;
    localparam logic [2:0] SLOTS_DOUBLE_M1 = 3'd3;

    localparam logic REG_STATION = 1'b0;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  group;
        logic [7:0]  variation;
        logic [7:0]  qualifier;
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] count;
        logic [7:0]  data;
        logic [15:0] base;
        logic [2:0]  last_slot;
    } t_job;

    function automatic logic range_ok(input logic [3:0] code);
        case (code)
            RC_SS8, RC_SS16, RC_NONE, RC_CNT8, RC_CNT16, RC_CNT8_ALT: range_ok = 1'b1;
            default: range_ok = 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] range_len(input logic [3:0] code);
        case (code)
            RC_SS8:      range_len = 3'd2;
            RC_SS16:     range_len = 3'd4;
            RC_CNT8:     range_len = 3'd1;
            RC_CNT16:    range_len = 3'd2;
            RC_CNT8_ALT: range_len = 3'd1;
            default:     range_len = 3'd0;
        endcase
    endfunction

    function automatic logic is_start_stop(input logic [3:0] code);
        is_start_stop = (code == RC_SS8) || (code == RC_SS16);
    endfunction

    function automatic logic is_count(input logic [3:0] code);
        is_count = (code == RC_CNT8) || (code == RC_CNT16) || (code == RC_CNT8_ALT);
    endfunction

endpackage

/* hw/rtl/dnp3oh_front.sv */
// Front end: accepts bytes, tracks the header phase and turns bytes into jobs.
// Depends on dnp3oh_pkg; feeds dnp3oh_queue.
module dnp3oh_front
    import dnp3oh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_header_start,
    input  logic       i_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_job       o_job
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_group, n_group;
    logic [7:0]  r_var, n_var;
    logic [7:0]  r_qual, n_qual;
    logic [2:0]  r_rcount, n_rcount;
    logic [15:0] r_start, n_start;
    logic [15:0] r_stop, n_stop;
    logic [15:0] r_count, n_count;
    logic [16:0] r_next, n_next;

    logic        accept;
    logic        restart;
    logic        qual_bad;
    logic        finish;
    logic        go_body;
    logic        body_done;
    logic [3:0]  fin_code;
    logic        fin_ss;
    logic        fin_cnt;
    logic        fin_err;
    logic [16:0] remaining;
    logic [2:0]  slots_m1;
    logic [2:0]  take_m1;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign restart    = i_header_start || (r_phase == PH_GROUP);

    always_comb begin
        n_group   = r_group;
        n_var     = r_var;
        n_qual    = r_qual;
        n_rcount  = r_rcount;
        n_start   = r_start;
        n_stop    = r_stop;
        n_count   = r_count;
        n_next    = r_next;
        o_push    = 1'b0;
        o_job     = '0;
        qual_bad  = 1'b0;
        finish    = 1'b0;
        go_body   = 1'b0;
        body_done = 1'b0;
        remaining = {1'b0, r_stop} - r_next;
        slots_m1  = (r_group == GROUP_SINGLE) ? SLOTS_SINGLE_M1 : SLOTS_DOUBLE_M1;
        take_m1   = (remaining < {14'd0, slots_m1}) ? remaining[2:0] : slots_m1;

        if (accept) begin
            if (restart) begin
                n_group  = i_data_byte;
                n_var    = '0;
                n_qual   = '0;
                n_start  = '0;
                n_stop   = '0;
                n_count  = '0;
                n_rcount = '0;
                n_next   = '0;
            end else begin
                case (r_phase)
                    PH_VAR: begin
                        n_var = i_data_byte;
                    end
                    PH_QUAL: begin
                        n_qual   = i_data_byte;
                        n_rcount = '0;
                        if (!range_ok(i_data_byte[3:0])) begin
                            qual_bad = 1'b1;
                        end else if (range_len(i_data_byte[3:0]) == 3'd0) begin
                            finish = 1'b1;
                        end
                    end
                    PH_RANGE: begin
                        case (r_qual[3:0])
                            RC_SS8: begin
                                if (r_rcount == 3'd0) begin
                                    n_start = {8'h00, i_data_byte};
                                end else begin
                                    n_stop = {8'h00, i_data_byte};
                                end
                            end
                            RC_SS16: begin
                                case (r_rcount)
                                    3'd0:    n_start[7:0]  = i_data_byte;
                                    3'd1:    n_start[15:8] = i_data_byte;
                                    3'd2:    n_stop[7:0]   = i_data_byte;
                                    default: n_stop[15:8]  = i_data_byte;
                                endcase
                            end
                            RC_CNT16: begin
                                if (r_rcount == 3'd0) begin
                                    n_count[7:0] = i_data_byte;
                                end else begin
                                    n_count[15:8] = i_data_byte;
                                end
                            end
                            default: begin
                                n_count = {8'h00, i_data_byte};
                            end
                        endcase
                        n_rcount = r_rcount + 3'd1;
                        finish   = (n_rcount >= range_len(r_qual[3:0]));
                    end
                    PH_BODY: begin
                        o_push          = 1'b1;
                        o_job.kind      = RK_POINT;
                        o_job.group     = r_group;
                        o_job.variation = r_var;
                        o_job.qualifier = r_qual;
                        o_job.first     = r_start;
                        o_job.last      = r_stop;
                        o_job.data      = i_data_byte;
                        o_job.base      = r_next[15:0];
                        o_job.last_slot = take_m1;
                        n_next          = r_next + {14'd0, take_m1} + 17'd1;
                        body_done       = (n_next > {1'b0, r_stop});
                    end
                    default: ;
                endcase
            end
        end

        fin_code = n_qual[3:0];
        fin_ss   = is_start_stop(fin_code);
        fin_cnt  = is_count(fin_code);
        fin_err  = fin_ss && ((n_qual & QUAL_INDEX_MASK) != 8'h00);

        if (qual_bad) begin
            o_push          = 1'b1;
            o_job.kind      = RK_ERROR;
            o_job.group     = n_group;
            o_job.variation = n_var;
            o_job.qualifier = n_qual;
        end else if (finish) begin
            o_push          = 1'b1;
            o_job.kind      = fin_err ? RK_ERROR : RK_HEADER;
            o_job.group     = n_group;
            o_job.variation = n_var;
            o_job.qualifier = n_qual;
            o_job.first     = fin_ss ? n_start : 16'd0;
            o_job.last      = fin_ss ? n_stop : 16'd0;
            o_job.count     = fin_cnt ? n_count : 16'd0;
            go_body = !fin_err && fin_ss && (n_var == VAR_PACKED)
                      && ((n_group == GROUP_SINGLE) || (n_group == GROUP_DOUBLE))
                      && (n_start <= n_stop);
            if (go_body) begin
                n_next = {1'b0, n_start};
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (restart) begin
                n_phase = PH_VAR;
            end else begin
                case (r_phase)
                    PH_VAR:   n_phase = PH_QUAL;
                    PH_QUAL: begin
                        if (qual_bad) begin
                            n_phase = PH_SKIP;
                        end else if (finish) begin
                            n_phase = go_body ? PH_BODY : PH_SKIP;
                        end else begin
                            n_phase = PH_RANGE;
                        end
                    end
                    PH_RANGE: begin
                        if (finish) begin
                            n_phase = go_body ? PH_BODY : PH_SKIP;
                        end
                    end
                    PH_BODY: begin
                        if (body_done) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    default:  n_phase = PH_SKIP;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GROUP;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_group  <= n_group;
        r_var    <= n_var;
        r_qual   <= n_qual;
        r_rcount <= n_rcount;
        r_start  <= n_start;
        r_stop   <= n_stop;
        r_count  <= n_count;
        r_next   <= n_next;
    end

endmodule

/* hw/rtl/dnp3oh_queue.sv */
// Job queue between the front and back ends, a small register ring.
// Depends on dnp3oh_pkg for the job type.
module dnp3oh_queue
    import dnp3oh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* hw/rtl/dnp3oh_back.sv */
// Back end: expands each queued job into result requests, one per cycle unless the output stalls.
// Depends on dnp3oh_pkg; drains dnp3oh_queue into the output register.
module dnp3oh_back
    import dnp3oh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_job        i_head,
    input  logic [15:0] i_station,
    input  logic        i_out_stall,
    output logic        o_pop,
    output logic        o_out_valid,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_object_group,
    output logic [7:0]  o_object_variation,
    output logic [7:0]  o_qualifier_code,
    output logic [15:0] o_range_first,
    output logic [15:0] o_range_last,
    output logic [15:0] o_object_count,
    output logic [15:0] o_point_index,
    output logic [7:0]  o_point_flag,
    output logic [15:0] o_point_station,
    output logic        o_last
);

    logic [2:0] r_slot, n_slot;
    logic       r_valid, n_valid;
    logic       load;
    logic       at_end;
    logic       is_point;
    logic       bit_on;

    assign load     = i_head_valid && (!r_valid || !i_out_stall);
    assign at_end   = (r_slot == i_head.last_slot);
    assign o_pop    = load && at_end;
    assign is_point = (i_head.kind == RK_POINT);
    assign bit_on   = (i_head.group == GROUP_SINGLE)
                      ? i_head.data[r_slot]
                      : (i_head.data[{r_slot[1:0], 1'b0} +: 2] == DBL_ON);

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        if (load) begin
            n_slot  = at_end ? 3'd0 : r_slot + 3'd1;
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_result_kind      <= i_head.kind;
            o_object_group     <= i_head.group;
            o_object_variation <= i_head.variation;
            o_qualifier_code   <= i_head.qualifier;
            o_range_first      <= i_head.first;
            o_range_last       <= i_head.last;
            o_object_count     <= i_head.count;
            o_point_index      <= is_point ? i_head.base + {13'd0, r_slot} : 16'd0;
            o_point_flag       <= is_point ? (bit_on ? FLAG_ON : FLAG_OFF) : 8'h00;
            o_point_station    <= is_point ? i_station : 16'd0;
            o_last             <= at_end;
        end
    end

    assign o_out_valid = r_valid;

endmodule

/* hw/rtl/dnp3_object_header_and_packed_bit_parser_core.sv */
// Top level of the object header and packed bit parser: config register,
// front end, job queue and back end. Depends on dnp3oh_pkg and submodules.
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+-------------------------------
//   input    | i_in_valid / o_in_stall          | i_data_byte, i_header_start
//   output   | o_out_valid / i_out_stall        | o_result_kind .. o_last
//   config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// One byte is accepted per cycle while the job queue has room. The back end
// emits one result request per cycle unless the output is stalled: a header
// or error job gives one result, a packed body byte 1 to 8 results (up to 8
// single-bit or 4 double-bit points); the result loop sets the sustained rate.
// Reset is synchronous and active low; it clears the parse phase, queue
// pointers, slot counter, output valid and station register.
// Output stall holds the output register; the queue absorbs input meanwhile.
module dnp3_object_header_and_packed_bit_parser_core
    import dnp3oh_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_header_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_object_group,
    output logic [7:0]  o_object_variation,
    output logic [7:0]  o_qualifier_code,
    output logic [15:0] o_range_first,
    output logic [15:0] o_range_last,
    output logic [15:0] o_object_count,
    output logic [15:0] o_point_index,
    output logic [7:0]  o_point_flag,
    output logic [15:0] o_point_station,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_station;
    logic        cfg_write;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_valid;
    t_job        q_job;
    t_job        q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_STATION);
    assign prdata    = (paddr[2] == REG_STATION) ? {16'h0000, r_station} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= '0;
        end else if (cfg_write) begin
            r_station <= pwdata[15:0];
        end
    end

    dnp3oh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_data_byte    (i_data_byte),
        .i_header_start (i_header_start),
        .i_full         (q_full),
        .o_in_stall     (o_in_stall),
        .o_push         (q_push),
        .o_job          (q_job)
    );

    dnp3oh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    dnp3oh_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head_valid       (q_valid),
        .i_head             (q_head),
        .i_station          (r_station),
        .i_out_stall        (i_out_stall),
        .o_pop              (q_pop),
        .o_out_valid        (o_out_valid),
        .o_result_kind      (o_result_kind),
        .o_object_group     (o_object_group),
        .o_object_variation (o_object_variation),
        .o_qualifier_code   (o_qualifier_code),
        .o_range_first      (o_range_first),
        .o_range_last       (o_range_last),
        .o_object_count     (o_object_count),
        .o_point_index      (o_point_index),
        .o_point_flag       (o_point_flag),
        .o_point_station    (o_point_station),
        .o_last             (o_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_single_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind != RK_POINT)) |-> o_last)
        else $error("header or error result without last");

    a_point_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == RK_POINT))
            |-> ((o_point_flag == FLAG_ON) || (o_point_flag == FLAG_OFF)))
        else $error("point result with bad flag");

    a_non_point_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind != RK_POINT))
            |-> ((o_point_station == 16'd0) && (o_point_flag == 8'h00)))
        else $error("non-point result carries point data");

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the DNP3 object header and packed bit parser core.
// Results are predicted from the accepted bytes by an in-bench parser model and checked in order.
// Depends on dnp3oh_pkg and the core RTL only.
module tb;
    import dnp3oh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 48;
    localparam logic [2:0] STATION_ADDR = {REG_STATION, 2'b00};

    typedef struct {
        logic [7:0] data;
        logic       hdr;
        bit         hold;
    } byte_req_t;

    typedef struct {
        t_kind       kind;
        logic [7:0]  group;
        logic [7:0]  variation;
        logic [7:0]  qualifier;
        logic [15:0] first_idx;
        logic [15:0] last_idx;
        logic [15:0] count;
        logic [15:0] index;
        logic [7:0]  flag;
        logic [15:0] station;
        logic        is_last;
    } parse_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_header_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_object_group;
    logic [7:0]  o_object_variation;
    logic [7:0]  o_qualifier_code;
    logic [15:0] o_range_first;
    logic [15:0] o_range_last;
    logic [15:0] o_object_count;
    logic [15:0] o_point_index;
    logic [7:0]  o_point_flag;
    logic [15:0] o_point_station;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    byte_req_t     pending_bytes[$];
    parse_result_t due_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          byte_taken = 1'b0;
    int unsigned queued_bytes = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_checked = 0;
    int unsigned n_points = 0;
    int unsigned n_headers = 0;
    int unsigned n_errors = 0;
    int unsigned fail_count = 0;

    // parser model state
    logic [15:0] station_cfg = '0;
    t_phase      cur_phase = PH_GROUP;
    logic [7:0]  obj_group = '0;
    logic [7:0]  obj_var = '0;
    logic [7:0]  obj_qual = '0;
    logic [2:0]  range_seen = '0;
    logic [15:0] span_lo = '0;
    logic [15:0] span_hi = '0;
    logic [15:0] obj_count = '0;
    logic [16:0] next_index = '0;

    dnp3_object_header_and_packed_bit_parser_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_header_start     (i_header_start),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_object_group     (o_object_group),
        .o_object_variation (o_object_variation),
        .o_qualifier_code   (o_qualifier_code),
        .o_range_first      (o_range_first),
        .o_range_last       (o_range_last),
        .o_object_count     (o_object_count),
        .o_point_index      (o_point_index),
        .o_point_flag       (o_point_flag),
        .o_point_station    (o_point_station),
        .o_last             (o_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic int range_bytes(logic [3:0] code);
        case (code)
            RC_SS8:      return 2;
            RC_SS16:     return 4;
            RC_NONE:     return 0;
            RC_CNT8:     return 1;
            RC_CNT16:    return 2;
            RC_CNT8_ALT: return 1;
            default:     return -1;
        endcase
    endfunction

    function automatic parse_result_t make_result(t_kind k, bit with_range, logic [15:0] idx,
                                                  logic [7:0] flag, logic [15:0] stn);
        parse_result_t r;
        logic [3:0] code;
        bit ss, cnt;
        code = obj_qual[3:0];
        ss = (code == RC_SS8) || (code == RC_SS16);
        cnt = (code == RC_CNT8) || (code == RC_CNT16) || (code == RC_CNT8_ALT);
        r.kind = k;
        r.group = obj_group;
        r.variation = obj_var;
        r.qualifier = obj_qual;
        r.first_idx = (with_range && ss) ? span_lo : 16'h0000;
        r.last_idx = (with_range && ss) ? span_hi : 16'h0000;
        r.count = (with_range && cnt) ? obj_count : 16'h0000;
        r.index = idx;
        r.flag = flag;
        r.station = stn;
        r.is_last = 1'b1;
        return r;
    endfunction

    task automatic expect_result(parse_result_t r);
        due_results.insert(due_results.size(), r);
    endtask

    task automatic close_header();
        bit ss;
        ss = (obj_qual[3:0] == RC_SS8) || (obj_qual[3:0] == RC_SS16);
        if (ss && (obj_qual & QUAL_INDEX_MASK) != 8'h00) begin
            expect_result(make_result(RK_ERROR, 1'b1, 16'h0000, 8'h00, 16'h0000));
            cur_phase = PH_SKIP;
        end else begin
            expect_result(make_result(RK_HEADER, 1'b1, 16'h0000, 8'h00, 16'h0000));
            if (ss && obj_var == VAR_PACKED
                    && (obj_group == GROUP_SINGLE || obj_group == GROUP_DOUBLE)
                    && span_lo <= span_hi) begin
                next_index = {1'b0, span_lo};
                cur_phase = PH_BODY;
            end else begin
                cur_phase = PH_SKIP;
            end
        end
    endtask

    task automatic parse_byte(logic [7:0] b, logic hs);
        logic [3:0] code;
        logic [2:0] n;
        int len, slots, npts;
        bit on;
        parse_result_t r;
        if (hs || cur_phase == PH_GROUP) begin
            obj_group = b;
            obj_var = '0;
            obj_qual = '0;
            span_lo = '0;
            span_hi = '0;
            obj_count = '0;
            range_seen = '0;
            next_index = '0;
            cur_phase = PH_VAR;
            return;
        end
        case (cur_phase)
            PH_VAR: begin
                obj_var = b;
                cur_phase = PH_QUAL;
            end
            PH_QUAL: begin
                obj_qual = b;
                len = range_bytes(b[3:0]);
                if (len < 0) begin
                    expect_result(make_result(RK_ERROR, 1'b0, 16'h0000, 8'h00,
                                              16'h0000));
                    cur_phase = PH_SKIP;
                end else if (len == 0) begin
                    close_header();
                end else begin
                    range_seen = '0;
                    cur_phase = PH_RANGE;
                end
            end
            PH_RANGE: begin
                code = obj_qual[3:0];
                n = range_seen;
                len = range_bytes(code);
                case (code)
                    RC_SS8: begin
                        if (n == 3'd0) span_lo = {8'h00, b};
                        else span_hi = {8'h00, b};
                    end
                    RC_SS16: begin
                        case (n)
                            3'd0: span_lo[7:0] = b;
                            3'd1: span_lo[15:8] = b;
                            3'd2: span_hi[7:0] = b;
                            default: span_hi[15:8] = b;
                        endcase
                    end
                    RC_CNT16: begin
                        if (n == 3'd0) obj_count[7:0] = b;
                        else obj_count[15:8] = b;
                    end
                    default: obj_count = {8'h00, b};
                endcase
                range_seen = n + 3'd1;
                if (len < 0 || int'(range_seen) >= len) close_header();
            end
            PH_BODY: begin
                slots = (obj_group == GROUP_SINGLE) ? 8 : 4;
                npts = int'({1'b0, span_hi}) - int'(next_index) + 1;
                if (npts > slots) npts = slots;
                for (int s = 0; s < npts; s++) begin
                    if (obj_group == GROUP_SINGLE) on = b[s];
                    else on = (b[2*s +: 2] == DBL_ON);
                    r = make_result(RK_POINT, 1'b1, next_index[15:0],
                                    on ? FLAG_ON : FLAG_OFF, station_cfg);
                    r.is_last = (s == npts - 1);
                    expect_result(r);
                    next_index = next_index + 17'd1;
                end
                if (next_index > {1'b0, span_hi}) cur_phase = PH_SKIP;
            end
            default: cur_phase = PH_SKIP;
        endcase
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // accept requests into the model, then check results in order
    always @(posedge i_clk) begin
        parse_result_t want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_data_byte, i_header_start);
                byte_taken = 1'b1;
                bytes_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result_kind: expected no result, got 0x%0h", o_result_kind);
                    fail_count++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    results_checked++;
                    case (want.kind)
                        RK_POINT: n_points++;
                        RK_HEADER: n_headers++;
                        default: n_errors++;
                    endcase
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("object_group", want.group, o_object_group);
                    check_field("object_variation", want.variation, o_object_variation);
                    check_field("qualifier_code", want.qualifier, o_qualifier_code);
                    check_field("range_first", want.first_idx, o_range_first);
                    check_field("range_last", want.last_idx, o_range_last);
                    check_field("object_count", want.count, o_object_count);
                    check_field("point_index", want.index, o_point_index);
                    check_field("point_flag", want.flag, o_point_flag);
                    check_field("point_station", want.station, o_point_station);
                    check_field("last", want.is_last, o_last);
                end
            end
        end
    end

    // drive requests and output stall on the falling edge
    always @(negedge i_clk) begin
        byte_req_t nxt;
        if (!i_in_valid || byte_taken) begin
            byte_taken = 1'b0;
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(pending_bytes[0].hold && due_results.size() != 0)) begin
                nxt = pending_bytes[0];
                pending_bytes.delete(0);
                i_in_valid <= 1'b1;
                i_data_byte <= nxt.data;
                i_header_start <= nxt.hdr;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic push_byte(logic [7:0] data, logic hdr, bit hold);
        byte_req_t q;
        q.data = data;
        q.hdr = hdr;
        q.hold = hold;
        pending_bytes.insert(pending_bytes.size(), q);
        queued_bytes++;
    endtask

    task automatic push_run(input logic [7:0] run[], input bit flag_first, input bit hold);
        foreach (run[i]) push_byte(run[i], (i == 0) && flag_first, (i == 0) && hold);
    endtask

    task automatic queue_object();
        logic [7:0] seq[$];
        logic [7:0] grp, vr, ql;
        logic [3:0] code;
        int unsigned lo, hi, cap, slots, nbody, cut;
        bit packed_body;
        if ($urandom_range(99) < 8) begin
            push_byte(8'($urandom), 1'($urandom), 1'b0);
            return;
        end
        if ($urandom_range(9) < 7) grp = $urandom_range(1) ? GROUP_SINGLE : GROUP_DOUBLE;
        else grp = 8'($urandom);
        vr = ($urandom_range(9) < 8) ? VAR_PACKED : 8'($urandom);
        case ($urandom_range(11))
            0, 1, 2, 3: code = RC_SS8;
            4, 5: code = RC_SS16;
            6: code = RC_NONE;
            7: code = RC_CNT8;
            8: code = RC_CNT16;
            9: code = RC_CNT8_ALT;
            default: code = 4'($urandom);
        endcase
        ql = {1'($urandom), ($urandom_range(7) == 0) ? 3'($urandom) : 3'b000, code};
        cap = (code == RC_SS16) ? 32'hFFFF : 32'hFF;
        if (code == RC_SS16 && $urandom_range(2) == 0) lo = 32'hFFF0 + $urandom_range(15);
        else lo = $urandom_range(cap);
        hi = lo + $urandom_range(15);
        if (hi > cap) hi = cap;
        if ($urandom_range(9) == 0 && lo > 0) hi = $urandom_range(lo - 1);
        seq.insert(seq.size(), grp);
        seq.insert(seq.size(), vr);
        seq.insert(seq.size(), ql);
        case (code)
            RC_SS8: begin
                seq.insert(seq.size(), lo[7:0]);
                seq.insert(seq.size(), hi[7:0]);
            end
            RC_SS16: begin
                seq.insert(seq.size(), lo[7:0]);
                seq.insert(seq.size(), lo[15:8]);
                seq.insert(seq.size(), hi[7:0]);
                seq.insert(seq.size(), hi[15:8]);
            end
            RC_CNT8, RC_CNT8_ALT: seq.insert(seq.size(), 8'($urandom));
            RC_CNT16: begin
                seq.insert(seq.size(), 8'($urandom));
                seq.insert(seq.size(), 8'($urandom));
            end
            default: ;
        endcase
        packed_body = (code == RC_SS8 || code == RC_SS16) && ql[6:4] == 3'b000
                      && vr == VAR_PACKED && (grp == GROUP_SINGLE || grp == GROUP_DOUBLE)
                      && lo <= hi;
        slots = (grp == GROUP_SINGLE) ? 8 : 4;
        nbody = packed_body ? (hi - lo + slots) / slots : 0;
        nbody += $urandom_range(1);
        repeat (nbody) seq.insert(seq.size(), 8'($urandom));
        cut = seq.size();
        if ($urandom_range(9) == 0) cut = $urandom_range(seq.size(), 1);
        for (int i = 0; i < cut; i++) push_byte(seq[i], i == 0, 1'b0);
    endtask

    task automatic queue_random(int unsigned n);
        int unsigned stop_at;
        stop_at = queued_bytes + n;
        while (queued_bytes < stop_at) queue_object();
    endtask

    task automatic write_station(logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= STATION_ADDR;
        pwdata <= {16'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        station_cfg = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 55;
        write_station(16'hFFFF);
        push_run('{8'h01, 8'h01, 8'h00, 8'hFE, 8'hFF, 8'hFF}, 1'b0, 1'b0);
        push_run('{8'h03, 8'h01, 8'h00, 8'h00, 8'h03, 8'h9C}, 1'b1, 1'b0);
        push_run('{8'h03, 8'h01}, 1'b1, 1'b0);
        push_run('{8'h0A, 8'hFF, 8'hF5}, 1'b1, 1'b0);
        push_run('{8'h01, 8'h01, 8'h90, 8'h05, 8'h04}, 1'b1, 1'b1);
        push_run('{8'h01, 8'h01, 8'h00, 8'h09, 8'h02, 8'h00}, 1'b1, 1'b0);
        push_run('{8'h00, 8'h00, 8'h86, 8'h33}, 1'b1, 1'b0);
        push_run('{8'h14, 8'h02, 8'h0B, 8'h07, 8'h55}, 1'b1, 1'b0);
        drain();

        write_station(16'($urandom));
        queue_random(20);
        drain();

        send_idle_pct = 55;
        recv_idle_pct = 10;
        write_station(16'h0000);
        queue_random(20);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_station(16'($urandom));
        queue_random(20);
        drain();

        $display("covered %0d bytes, %0d results (%0d headers, %0d points, %0d errors)",
                 bytes_taken, results_checked, n_headers, n_points, n_errors);
        $display("over four station settings and three idle mixes");
        if (fail_count == 0) begin
            $display("dnp3_object_header_and_packed_bit_parser_core: match");
        end else begin
            $display("dnp3_object_header_and_packed_bit_parser_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("dnp3_object_header_and_packed_bit_parser_core: mismatch");
        $finish;
    end

endmodule
